// ===== rtl/ncdf_pkg.sv =====
`timescale 1ns / 1ps

package ncdf_pkg;

  // Multiplier chain geometry: 4 cells of 16-bit limbs, 64-bit operands
  localparam int LIMB_W = 16;
  localparam int NCELL  = 4;
  localparam int MUL_W  = LIMB_W * NCELL;

  // Fixed-point constants
  localparam logic [63:0] SAT_MAG   = 64'h3FFF_FFFF_FFFF_FFFF;
  localparam logic [31:0] SCALE_Q32 =
    32'((64'd39894228 * 64'd4294967296 + 64'd50000000) / 64'd100000000);
  localparam logic [15:0] QA_Q16 =
    16'((64'd68936564 * 64'd65536 + 64'd50000000) / 64'd100000000);
  localparam logic [17:0] QB_Q16 =
    18'((64'd250832137 * 64'd65536 + 64'd50000000) / 64'd100000000);
  localparam logic [15:0] QC_Q16 =
    16'((64'd93954765 * 64'd65536 + 64'd50000000) / 64'd100000000);
  localparam logic [16:0] HALF_Q16 = 17'd32768;
  localparam logic [16:0] ONE_Q16  = 17'd65536;

  // Request into the multiplier chain
  typedef struct packed {
    logic             start;
    logic [MUL_W-1:0] a;
    logic [MUL_W-1:0] b;
  } mul_req_t;

  // Full product {hi, lo} plus a one-cycle done strobe
  typedef struct packed {
    logic             done;
    logic [MUL_W:0]   hi;
    logic [MUL_W-1:0] lo;
  } mul_rsp_t;

endpackage

// ===== rtl/ncdf_cell.sv =====
`timescale 1ns / 1ps

// One limb of the multiplier: holds a multiplicand limb and an accumulator limb.
module ncdf_cell import ncdf_pkg::*; (
  input  logic              clk,
  input  logic              load,
  input  logic              step,
  input  logic [LIMB_W-1:0] a_in,
  input  logic [LIMB_W-1:0] digit,
  input  logic [LIMB_W-1:0] limb_in,
  input  logic [LIMB_W:0]   carry_in,
  output logic [LIMB_W-1:0] sum_limb,
  output logic [LIMB_W-1:0] acc_q,
  output logic [LIMB_W:0]   carry_out
);

  localparam int SW = 2 * LIMB_W + 1;

  logic [LIMB_W-1:0] a_r;
  logic [LIMB_W-1:0] acc_r;
  logic [SW-1:0]     s;

  // limb product plus own accumulator plus carry from the lower neighbor
  assign s = SW'(a_r) * SW'(digit) + SW'(acc_r) + SW'(carry_in);
  assign sum_limb  = s[LIMB_W-1:0];
  assign carry_out = s[SW-1:LIMB_W];
  assign acc_q     = acc_r;

  // accumulator takes the upper neighbor's limb: shift down one limb per step
  always_ff @(posedge clk) begin
    if (load) begin
      a_r   <= a_in;
      acc_r <= '0;
    end else if (step) begin
      acc_r <= limb_in;
    end
  end

endmodule

// ===== rtl/ncdf_mul.sv =====
`timescale 1ns / 1ps

// Digit-serial multiplier: a row of limb cells, one 16-bit digit of b per cycle.
module ncdf_mul import ncdf_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  mul_req_t req,
  output mul_rsp_t rsp
);

  localparam int CW = $clog2(NCELL);

  logic [MUL_W-1:0]  b_r;
  logic [MUL_W-1:0]  lo_r;
  logic              top_r;
  logic [CW-1:0]     cnt_r;
  logic              busy_r;
  logic              done_r;

  logic [LIMB_W:0]   carry [0:NCELL];
  logic [LIMB_W-1:0] sum_limb [0:NCELL-1];
  logic [LIMB_W-1:0] acc_q [0:NCELL-1];
  logic [LIMB_W:0]   top_sum;

  assign carry[0] = '0;
  assign top_sum  = (LIMB_W+1)'(top_r) + carry[NCELL];

  // cell row
  for (genvar i = 0; i < NCELL; i++) begin : g_cell
    logic [LIMB_W-1:0] limb_in;
    if (i == NCELL - 1) begin : g_top
      assign limb_in = top_sum[LIMB_W-1:0];
    end else begin : g_mid
      assign limb_in = sum_limb[i+1];
    end

    ncdf_cell u_cell (
      .clk       (clk),
      .load      (req.start),
      .step      (busy_r),
      .a_in      (req.a[i*LIMB_W +: LIMB_W]),
      .digit     (b_r[LIMB_W-1:0]),
      .limb_in   (limb_in),
      .carry_in  (carry[i]),
      .sum_limb  (sum_limb[i]),
      .acc_q     (acc_q[i]),
      .carry_out (carry[i+1])
    );

    assign rsp.hi[i*LIMB_W +: LIMB_W] = acc_q[i];
  end

  assign rsp.hi[MUL_W] = top_r;
  assign rsp.lo        = lo_r;
  assign rsp.done      = done_r;

  // digit sequencing; low product limbs shift out into lo_r
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        b_r    <= req.b;
        top_r  <= 1'b0;
      end else if (busy_r) begin
        b_r   <= b_r >> LIMB_W;
        lo_r  <= {sum_limb[0], lo_r[MUL_W-1:LIMB_W]};
        top_r <= top_sum[LIMB_W];
        cnt_r <= CW'(cnt_r + 1'b1);
        if (cnt_r == CW'(NCELL - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== rtl/normal_cdf_taylor_series_top.sv =====
`timescale 1ns / 1ps

// Standard normal CDF by Maclaurin series, one item at a time.
// Input channel: in_valid/in_ready with in_x_value (Q3.12 signed) and in_mode
// (0 = term count from cfg register, 1 = fitted count with clamp at |x| >= 4).
// Output channel: out_valid/out_ready with out_cdf_value (Q1.16, 0..65536) and
// out_terms_used.
// Config: cfg_we/cfg_wdata write term_count (reset value 5); write it only while
// idle, which the block itself does not enforce. Every product goes through a
// 4-cell limb multiplier that takes one 16-bit digit per cycle. An item with n
// terms needs 2n+2 products; dynamic mode adds the fit states S_FIT1 and S_FIT2
// first, and a clamped item goes straight to the finish state.
// The next item is accepted once the result sits in the output register.
// Reset returns to idle with no result pending and term_count = 5.
// A stalled receiver holds the output register; the following item is then
// computed and waits in the finish state until the register frees up.
module normal_cdf_taylor_series_top import ncdf_pkg::*; #(
  parameter int MAX_TERMS   = 30,
  parameter int X_FRAC_BITS = 12
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] in_x_value,
  input  logic               in_mode,
  output logic               out_valid,
  input  logic               out_ready,
  output logic        [16:0] out_cdf_value,
  output logic        [4:0]  out_terms_used,
  input  logic               cfg_we,
  input  logic        [4:0]  cfg_wdata
);

  localparam int NW = $clog2(MAX_TERMS + 1);
  localparam int signed LIM4 = 4 << X_FRAC_BITS;

  typedef enum logic [2:0] {S_IDLE, S_FIT1, S_FIT2, S_SETUP, S_MULW, S_FIN} state_t;
  typedef enum logic [1:0] {OP_SQ, OP_TX2, OP_TC, OP_SCALE} op_t;

  state_t             state_r;
  op_t                op_r;
  logic [4:0]         cfg_term_count_r;
  logic               neg_r;
  logic [16:0]        mag_r;
  logic [25:0]        inner_r;
  logic [NW-1:0]      n_r;
  logic [NW-1:0]      k_r;
  logic [63:0]        x2_r;
  logic [63:0]        t_r;
  logic signed [63:0] sum_r;
  logic               tneg_r;
  logic               sneg_r;
  logic [16:0]        res_cdf_r;
  logic [4:0]         res_terms_r;
  logic               out_valid_r;
  logic [16:0]        out_cdf_r;
  logic [4:0]         out_terms_r;
  mul_req_t           mreq_r;
  mul_rsp_t           mrsp;

  logic [31:0]        coeff_rom [1:MAX_TERMS];

  // coefficient ROM: c_k = (2k-1)/(2k(2k+1)) in Q.32
  for (genvar g = 1; g <= MAX_TERMS; g++) begin : g_rom
    localparam longint unsigned DEN = 64'(2 * g) * 64'(2 * g + 1);
    localparam longint unsigned CQ  = ((64'(2 * g - 1) << 32) + DEN / 2) / DEN;
    assign coeff_rom[g] = 32'(CQ);
  end

  ncdf_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mreq_r),
    .rsp   (mrsp)
  );

  logic signed [31:0] xv;
  logic [NW-1:0]      fixed_n;
  logic [33:0]        p1;
  logic [25:0]        inner_nxt;
  logic [42:0]        p2;
  logic [42:0]        q;
  logic [26:0]        fitn;
  logic [NW-1:0]      fit_n;
  logic [63:0]        xq;
  logic [63:0]        sat32;
  logic signed [63:0] tval;
  logic signed [63:0] sum_add;
  logic signed [63:0] sum_sat;
  logic [63:0]        abs_new;
  logic [63:0]        abs_cur;
  logic               ge;
  logic [16:0]        r_lo;
  logic [16:0]        cdf_val;

  // per-item setup and term-count fit
  always_comb begin
    xv        = 32'(in_x_value);
    fixed_n   = (int'(cfg_term_count_r) > MAX_TERMS) ? NW'(MAX_TERMS)
                                                      : NW'(cfg_term_count_r);
    p1        = 34'(mag_r) * 34'(QC_Q16);
    inner_nxt = 26'(26'(QB_Q16) + 26'(p1 >> X_FRAC_BITS));
    p2        = 43'(mag_r) * 43'(inner_r);
    q         = 43'(QA_Q16) + (p2 >> X_FRAC_BITS);
    fitn      = q[42:16];
    fit_n     = (fitn > 27'(MAX_TERMS)) ? NW'(MAX_TERMS) : NW'(fitn);
    xq        = 64'(mag_r) << (32 - X_FRAC_BITS);
  end

  // product post-processing: >>32 with saturation, signed accumulate, final scale
  always_comb begin
    sat32   = (mrsp.hi[64:30] != '0) ? SAT_MAG : {2'b00, mrsp.hi[29:0], mrsp.lo[63:32]};
    tval    = tneg_r ? $signed(sat32) : -$signed(sat32);
    sum_add = sum_r + tval;
    if (sum_add > $signed(SAT_MAG)) begin
      sum_sat = $signed(SAT_MAG);
    end else if (sum_add < -$signed(SAT_MAG)) begin
      sum_sat = -$signed(SAT_MAG);
    end else begin
      sum_sat = sum_add;
    end
    abs_new = sum_sat[63] ? 64'(-sum_sat) : 64'(sum_sat);
    abs_cur = sum_r[63] ? 64'(-sum_r) : 64'(sum_r);
    ge      = (mrsp.hi != '0) || mrsp.lo[63];
    r_lo    = {2'b00, mrsp.lo[62:48]};
    if (sneg_r) begin
      cdf_val = ge ? 17'd0 : 17'(HALF_Q16 - r_lo);
    end else begin
      cdf_val = ge ? ONE_Q16 : 17'(HALF_Q16 + r_lo);
    end
  end

  assign in_ready       = (state_r == S_IDLE);
  assign out_valid      = out_valid_r;
  assign out_cdf_value  = out_cdf_r;
  assign out_terms_used = out_terms_r;

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r          <= S_IDLE;
      op_r             <= OP_SQ;
      out_valid_r      <= 1'b0;
      mreq_r.start     <= 1'b0;
      cfg_term_count_r <= 5'd5;
    end else begin
      // multiplier launch: first product at setup, next one on each done except the scale done
      mreq_r.start <= (state_r == S_SETUP) ||
                      (state_r == S_MULW && mrsp.done && op_r != OP_SCALE);
      if (cfg_we) begin
        cfg_term_count_r <= cfg_wdata;
      end
      // output register load or drain
      if (state_r == S_FIN && (!out_valid_r || out_ready)) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            neg_r <= in_x_value[15];
            mag_r <= in_x_value[15] ? 17'(ONE_Q16 - {1'b0, in_x_value})
                                    : {1'b0, in_x_value};
            if (in_mode) begin
              if (xv >= LIM4) begin
                res_cdf_r   <= ONE_Q16;
                res_terms_r <= 5'd0;
                state_r     <= S_FIN;
              end else if (xv <= -LIM4) begin
                res_cdf_r   <= 17'd0;
                res_terms_r <= 5'd0;
                state_r     <= S_FIN;
              end else begin
                state_r <= S_FIT1;
              end
            end else begin
              n_r     <= fixed_n;
              state_r <= S_SETUP;
            end
          end
        end
        S_FIT1: begin
          inner_r <= inner_nxt;
          state_r <= S_FIT2;
        end
        S_FIT2: begin
          n_r     <= fit_n;
          state_r <= S_SETUP;
        end
        S_SETUP: begin
          t_r          <= xq;
          sum_r        <= neg_r ? -$signed(xq) : $signed(xq);
          tneg_r       <= neg_r;
          k_r          <= NW'(1);
          mreq_r.a     <= xq;
          mreq_r.b     <= xq;
          op_r         <= OP_SQ;
          state_r      <= S_MULW;
        end
        S_MULW: begin
          if (mrsp.done) begin
            case (op_r)
              OP_SQ: begin
                x2_r <= sat32;
                if (n_r == '0) begin
                  sneg_r   <= sum_r[63];
                  mreq_r.a <= abs_cur;
                  mreq_r.b <= 64'(SCALE_Q32);
                  op_r     <= OP_SCALE;
                end else begin
                  mreq_r.a <= t_r;
                  mreq_r.b <= sat32;
                  op_r     <= OP_TX2;
                end
              end
              OP_TX2: begin
                mreq_r.a <= sat32;
                mreq_r.b <= 64'(coeff_rom[k_r]);
                op_r     <= OP_TC;
              end
              OP_TC: begin
                t_r    <= sat32;
                tneg_r <= !tneg_r;
                sum_r  <= sum_sat;
                if (k_r == n_r) begin
                  sneg_r   <= sum_sat[63];
                  mreq_r.a <= abs_new;
                  mreq_r.b <= 64'(SCALE_Q32);
                  op_r     <= OP_SCALE;
                end else begin
                  k_r      <= NW'(k_r + 1'b1);
                  mreq_r.a <= sat32;
                  mreq_r.b <= x2_r;
                  op_r     <= OP_TX2;
                end
              end
              OP_SCALE: begin
                res_cdf_r    <= cdf_val;
                res_terms_r  <= 5'(n_r);
                state_r      <= S_FIN;
              end
              default: begin
                state_r      <= S_IDLE;
              end
            endcase
          end
        end
        S_FIN: begin
          if (!out_valid_r || out_ready) begin
            out_cdf_r   <= res_cdf_r;
            out_terms_r <= res_terms_r;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // result never exceeds 1.0
  a_cdf_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_cdf_value <= ONE_Q16)
    else $error("cdf above 1.0");

  // term index stays within the selected count
  a_term_index: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MULW && op_r == OP_TC) |-> (k_r != '0 && k_r <= n_r))
    else $error("term index out of range");

  // multiplier only finishes while the sequencer waits for it
  a_mul_done: assert property (@(posedge clk) disable iff (!rst_n)
    mrsp.done |-> state_r == S_MULW)
    else $error("unexpected multiplier done");

  // running sum stays inside the saturation bounds
  a_sum_sat: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MULW) |-> (sum_r <= $signed(SAT_MAG) && sum_r >= -$signed(SAT_MAG)))
    else $error("sum out of saturation range");

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import ncdf_pkg::*;

  localparam int MAX_N      = 30;
  localparam int FRAC       = 12;
  localparam int CYCLE_LIMIT = 2000000;
  localparam logic [63:0] MAG_SAT = 64'h3FFF_FFFF_FFFF_FFFF;

  typedef struct {
    logic [16:0] cdf;
    logic [4:0]  terms;
  } cdf_result_t;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic signed [15:0] in_x_value;
  logic               in_mode;
  logic               out_valid;
  logic               out_ready;
  logic        [16:0] out_cdf_value;
  logic        [4:0]  out_terms_used;
  logic               cfg_we;
  logic        [4:0]  cfg_wdata;

  cdf_result_t cdf_expected_q[$];
  logic [4:0]  term_count_m;
  int          error_count;
  int          cycle_count;
  bit          rx_quiet;     // receiver never stalls
  bit          tx_quiet;     // sender never idles
  bit          rx_hold;      // long receiver hold-off

  normal_cdf_taylor_series_top #(.MAX_TERMS(30), .X_FRAC_BITS(12)) uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_x_value(in_x_value), .in_mode(in_mode),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_cdf_value(out_cdf_value), .out_terms_used(out_terms_used),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  // clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // (a*b) >> sh, saturated to lim
  function automatic logic [63:0] mul_shift_sat(logic [63:0] a, logic [63:0] b, int sh,
                                                logic [63:0] lim);
    logic [127:0] p;
    p = ({64'd0, a} * {64'd0, b}) >> sh;
    if (p > {64'd0, lim}) return lim;
    return p[63:0];
  endfunction

  function automatic logic [63:0] series_coeff(int k);
    logic [63:0] den;
    den = 64'(2 * k) * 64'(2 * k + 1);
    return ((64'(2 * k - 1) << 32) + den / 2) / den;
  endfunction

  function automatic logic [63:0] fitted_count(logic [63:0] z);
    logic [63:0] inner, q;
    inner = 64'(QB_Q16) + ((z * 64'(QC_Q16)) >> FRAC);
    q = 64'(QA_Q16) + ((z * inner) >> FRAC);
    return q >> 16;
  endfunction

  // predicted CDF for one item
  function automatic cdf_result_t predict_cdf(logic signed [15:0] x, logic mode);
    cdf_result_t res;
    logic [63:0] mag, n, xq, x2, t, r;
    logic signed [63:0] sum;
    bit tneg;
    mag = (x < 0) ? 64'(-32'(x)) : 64'(x);
    tneg = (x < 0);
    if (mode) begin
      if (x >= 16'sd16384 || x <= -16'sd16384) begin
        res.cdf = (x > 0) ? ONE_Q16 : 17'd0;
        res.terms = 5'd0;
        return res;
      end
      n = fitted_count(mag);
    end else begin
      n = 64'(term_count_m);
    end
    if (n > MAX_N) n = MAX_N;
    xq = mag << (32 - FRAC);
    x2 = mul_shift_sat(xq, xq, 32, MAG_SAT);
    t = xq;
    sum = tneg ? -$signed(t) : $signed(t);
    for (int k = 1; k <= n; k++) begin
      t = mul_shift_sat(t, x2, 32, MAG_SAT);
      t = mul_shift_sat(t, series_coeff(k), 32, MAG_SAT);
      tneg = !tneg;
      sum = sum + (tneg ? -$signed(t) : $signed(t));
      if (sum > $signed(MAG_SAT)) sum = $signed(MAG_SAT);
      if (sum < -$signed(MAG_SAT)) sum = -$signed(MAG_SAT);
    end
    if (sum < 0) begin
      r = mul_shift_sat(64'(-sum), 64'(SCALE_Q32), 48, 64'd1 << 20);
      res.cdf = (r >= 32768) ? 17'd0 : 17'(32768 - r);
    end else begin
      r = mul_shift_sat(64'(sum), 64'(SCALE_Q32), 48, 64'd1 << 20);
      res.cdf = (r >= 32768) ? ONE_Q16 : 17'(32768 + r);
    end
    res.terms = 5'(n);
    return res;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("ERROR %0t: %s got %0d expected %0d", $realtime, what, got, want);
    error_count++;
  endtask

  // send one item and queue its prediction; valid stays up if another item follows
  task automatic send_item(logic signed [15:0] x, logic mode);
    while (!tx_quiet && $urandom_range(99) < 16) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_x_value <= x;
    in_mode    <= mode;
    cdf_expected_q.push_back(predict_cdf(x, mode));
    do @(posedge clk); while (!in_ready);
  endtask

  // wait for drain, then write term_count while idle
  task automatic write_term_count(logic [4:0] v);
    int guard;
    guard = 0;
    in_valid <= 1'b0;
    while (cdf_expected_q.size() != 0 && guard < 100000) begin
      @(posedge clk);
      guard++;
    end
    repeat (400) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    term_count_m = v;
  endtask

  // receiver ready
  always @(posedge clk) begin
    if (rx_hold) out_ready <= 1'b0;
    else out_ready <= rx_quiet || ($urandom_range(99) >= 16);
  end

  // result checker
  always @(posedge clk) begin
    cdf_result_t e;
    if (rst_n && out_valid && out_ready) begin
      if (cdf_expected_q.size() == 0) begin
        report_mismatch("unexpected item, cdf", out_cdf_value, 0);
      end else begin
        e = cdf_expected_q.pop_front();
        if (out_cdf_value !== e.cdf) report_mismatch("cdf_value", out_cdf_value, e.cdf);
        if (out_terms_used !== e.terms)
          report_mismatch("terms_used", out_terms_used, e.terms);
      end
    end
  end

  // timeout
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic test_fixed_extremes();
    logic [4:0] counts[4] = '{5'd0, 5'd1, 5'd30, 5'd31};
    foreach (counts[i]) begin
      write_term_count(counts[i]);
      send_item(16'sh7FFF, 1'b0);
      send_item(-16'sh8000, 1'b0);
      send_item(16'sd0, 1'b0);
      send_item(16'sd4096, 1'b0);
    end
  endtask

  task automatic test_dynamic_special();
    send_item(16'sd16384, 1'b1);
    send_item(-16'sd16384, 1'b1);
    send_item(16'sd16383, 1'b1);
    send_item(-16'sd16383, 1'b1);
    send_item(16'sh7FFF, 1'b1);
    send_item(-16'sh8000, 1'b1);
    send_item(16'sd0, 1'b1);
    send_item(16'sd1, 1'b1);
    send_item(-16'sd1, 1'b1);
  endtask

  // receiver holds off while sender keeps offering
  task automatic test_backpressure();
    rx_hold = 1'b1;
    fork
      repeat (3000) @(posedge clk);
      repeat (6) send_item(16'($urandom_range(32767) - 16384), 1'($urandom_range(1)));
    join_any
    rx_hold = 1'b0;
    wait fork;
  endtask

  task automatic test_random(int count);
    logic signed [15:0] x;
    for (int i = 0; i < count; i++) begin
      if (i % 250 == 0) begin
        write_term_count(5'($urandom_range(31)));
        tx_quiet = (i == 500);
        rx_quiet = (i == 500);
      end
      case ($urandom_range(3))
        0: x = 16'($urandom);
        1: x = 16'($urandom_range(32767) - 16384);
        2: x = 16'($urandom_range(2047) - 1024);
        default: x = 16'(($urandom_range(16500) - 8250) * 2);
      endcase
      send_item(x, 1'($urandom_range(1)));
    end
    tx_quiet = 1'b0;
    rx_quiet = 1'b0;
  endtask

  initial begin
    int guard;
    rst_n = 1'b0; in_valid = 1'b0; in_x_value = '0; in_mode = 1'b0;
    out_ready = 1'b0; cfg_we = 1'b0; cfg_wdata = '0;
    error_count = 0; cycle_count = 0;
    rx_quiet = 1'b0; tx_quiet = 1'b0; rx_hold = 1'b0;
    term_count_m = 5'd5;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    send_item(16'sd2048, 1'b0);   // reset term count
    test_fixed_extremes();
    test_dynamic_special();
    test_backpressure();
    test_random(1120);
    in_valid <= 1'b0;
    guard = 0;
    while (cdf_expected_q.size() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (400) @(posedge clk);
    if (error_count == 0 && cdf_expected_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
